>>> src/lfbp_pkg.sv
// Package: shared constants, types and control/status structs of the bit packer.
`timescale 1ns / 1ps
package lfbp_pkg;

  localparam int VALUE_BITS     = 32;  // low field bits taken from the value
  localparam int MAX_FIELD_BITS = 64;  // widest field one put may write
  localparam int IN_VALUE_W     = 32;
  localparam int BIT_COUNT_W    = 7;
  localparam int BYTE_W         = 8;
  localparam int PEND_CNT_W     = 3;

  localparam int ACC_W      = MAX_FIELD_BITS + BYTE_W;
  localparam int WIDTH_W    = $clog2(MAX_FIELD_BITS + 1);
  localparam int TOTAL_W    = $clog2(MAX_FIELD_BITS + BYTE_W);
  localparam int BYTE_CNT_W = TOTAL_W - PEND_CNT_W;

  localparam logic OP_PUT     = 1'b0;
  localparam logic OP_DISCARD = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } lfbp_state_t;

  typedef struct packed {
    logic load;
    logic discard;
    logic emit;
  } lfbp_cmd_t;

  typedef struct packed {
    logic is_discard;
    logic no_bytes;
    logic last_byte;
  } lfbp_status_t;

endpackage

>>> src/lfbp_if.sv
// Interfaces: input item channel and output byte channel.
`timescale 1ns / 1ps
interface lfbp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [lfbp_pkg::IN_VALUE_W-1:0]  value;
  logic                             is_signed;
  logic [lfbp_pkg::BIT_COUNT_W-1:0] bit_count;

  modport source (output valid, operation, value, is_signed, bit_count, input ready);
  modport sink   (input valid, operation, value, is_signed, bit_count, output ready);
endinterface

interface lfbp_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfbp_pkg::BYTE_W-1:0] out_byte;
  logic                        last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

>>> src/lfbp_ctrl.sv
// Controller: accept/emit sequencing and output valid flag.
`timescale 1ns / 1ps
module lfbp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  lfbp_pkg::lfbp_status_t status,
  output lfbp_pkg::lfbp_cmd_t    cmd
);

  lfbp_pkg::lfbp_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic slot_free;

  assign in_ready  = (state_r == lfbp_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load    = accept && !status.is_discard;
    cmd.discard = accept && status.is_discard;
    cmd.emit    = (state_r == lfbp_pkg::S_EMIT) && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfbp_pkg::S_IDLE: begin
        if (cmd.load && !status.no_bytes) state_nxt = lfbp_pkg::S_EMIT;
      end
      lfbp_pkg::S_EMIT: begin
        if (cmd.emit && status.last_byte) state_nxt = lfbp_pkg::S_IDLE;
      end
      default: state_nxt = lfbp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfbp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> src/lfbp_dp.sv
// Datapath: field build, bit accumulator, byte counter and output register.
`timescale 1ns / 1ps
module lfbp_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_operation,
  input  logic [lfbp_pkg::IN_VALUE_W-1:0]   in_value,
  input  logic                              in_is_signed,
  input  logic [lfbp_pkg::BIT_COUNT_W-1:0]  in_bit_count,
  input  lfbp_pkg::lfbp_cmd_t               cmd,
  output lfbp_pkg::lfbp_status_t            status,
  output logic [lfbp_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_last
);

  logic [lfbp_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic [lfbp_pkg::PEND_CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [lfbp_pkg::BYTE_CNT_W-1:0] bytes_r, bytes_nxt;
  logic [lfbp_pkg::BYTE_W-1:0]     out_byte_r;
  logic                            out_last_r;

  logic [lfbp_pkg::WIDTH_W-1:0]        width_c;
  logic                                sign_bit;
  logic                                fill;
  logic [lfbp_pkg::MAX_FIELD_BITS-1:0] field;
  logic [lfbp_pkg::TOTAL_W-1:0]        total;

  // clamp the requested width
  always_comb begin
    if (32'(in_bit_count) > 32'(lfbp_pkg::MAX_FIELD_BITS))
      width_c = lfbp_pkg::WIDTH_W'(lfbp_pkg::MAX_FIELD_BITS);
    else
      width_c = lfbp_pkg::WIDTH_W'(in_bit_count);
  end

  always_comb begin
    if (lfbp_pkg::VALUE_BITS <= lfbp_pkg::IN_VALUE_W)
      sign_bit = in_value[(lfbp_pkg::VALUE_BITS - 1) % lfbp_pkg::IN_VALUE_W];
    else
      sign_bit = 1'b0;
    fill = in_is_signed && sign_bit;
  end

  // per-bit field select: value bits, then sign fill, masked to width
  always_comb begin
    for (int i = 0; i < lfbp_pkg::MAX_FIELD_BITS; i++) begin
      if (i >= int'(width_c))
        field[i] = 1'b0;
      else if (i >= lfbp_pkg::VALUE_BITS)
        field[i] = fill;
      else if (i >= lfbp_pkg::IN_VALUE_W)
        field[i] = 1'b0;
      else
        field[i] = in_value[i % lfbp_pkg::IN_VALUE_W];
    end
  end

  assign total = lfbp_pkg::TOTAL_W'(pend_cnt_r) + lfbp_pkg::TOTAL_W'(width_c);

  always_comb begin
    status.is_discard = (in_operation == lfbp_pkg::OP_DISCARD);
    status.no_bytes   = (total[lfbp_pkg::TOTAL_W-1:lfbp_pkg::PEND_CNT_W] == '0);
    status.last_byte  = (bytes_r == lfbp_pkg::BYTE_CNT_W'(1));
  end

  always_comb begin
    acc_nxt      = acc_r;
    pend_cnt_nxt = pend_cnt_r;
    bytes_nxt    = bytes_r;
    priority if (cmd.discard) begin
      acc_nxt      = '0;
      pend_cnt_nxt = '0;
    end else if (cmd.load) begin
      // new field lands just above the pending bits
      acc_nxt      = (lfbp_pkg::ACC_W'(field) << pend_cnt_r)
                   | lfbp_pkg::ACC_W'(acc_r[lfbp_pkg::BYTE_W-1:0]);
      pend_cnt_nxt = total[lfbp_pkg::PEND_CNT_W-1:0];
      bytes_nxt    = total[lfbp_pkg::TOTAL_W-1:lfbp_pkg::PEND_CNT_W];
    end else if (cmd.emit) begin
      acc_nxt   = acc_r >> lfbp_pkg::BYTE_W;
      bytes_nxt = bytes_r - lfbp_pkg::BYTE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      pend_cnt_r <= '0;
      bytes_r    <= '0;
    end else begin
      acc_r      <= acc_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      bytes_r    <= bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= acc_r[lfbp_pkg::BYTE_W-1:0];
      out_last_r <= status.last_byte;
    end
  end

  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

endmodule

>>> src/lsb_first_bit_packer.sv
// Top level: LSB-first variable-width bit packer.
//
//   channel | dir | payload                                  | transfer when
//   in_ch   | in  | operation, value, is_signed, bit_count    | valid && ready
//   out_ch  | out | out_byte, last                           | valid && ready
//
// A put that completes N bytes (0..8) emits them one per cycle while
// out_ch is ready, through the single 8-bit output register fed from
// the accumulator's low byte; no new item is taken until its last byte
// is emitted. A put that completes no byte leaves in_ch.ready high.
// Reset (rst_n low, synchronous) clears the pending bits and output valid.
// in_ch.ready is high whenever no bytes of an earlier item remain to be
// emitted; a stalled out_ch holds the byte and pauses emission.
`timescale 1ns / 1ps
module lsb_first_bit_packer (
  input logic        clk,
  input logic        rst_n,
  lfbp_in_if.sink    in_ch,
  lfbp_out_if.source out_ch
);

  lfbp_pkg::lfbp_cmd_t    cmd;
  lfbp_pkg::lfbp_status_t status;

  // sequencing: idle/emit state, output valid flag
  lfbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // bit accumulator holds pending bits in its low byte between items
  lfbp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_ch.operation),
    .in_value     (in_ch.value),
    .in_is_signed (in_ch.is_signed),
    .in_bit_count (in_ch.bit_count),
    .cmd          (cmd),
    .status       (status),
    .out_byte     (out_ch.out_byte),
    .out_last     (out_ch.last)
  );

endmodule

>>> verif/tb_lsb_first_bit_packer.sv
// Testbench for the LSB-first bit packer: random and directed puts/discards, scoreboarded bytes.
`timescale 1ns / 1ps
module tb_lsb_first_bit_packer;

  // Expected byte plus its end-of-item flag.
  typedef struct packed {
    logic [lfbp_pkg::BYTE_W-1:0] data;
    logic                        last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  lfbp_in_if  in_ch ();
  lfbp_out_if out_ch ();

  lsb_first_bit_packer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: bits still waiting for a full byte.
  logic [lfbp_pkg::BYTE_W-1:0] held_bits;
  int unsigned                 held_count;

  // Bytes the packer still owes us, oldest first.
  packed_byte_t      owed_bytes_q[$];

  int                errors;
  bit                in_gaps_on;
  bit                out_gaps_on;
  int                hold_off_req;   // receiver hold-off request, in cycles
  int                hold_left;

  // Count a failure; only the first ten get printed.
  task automatic log_failure(input string what);
    errors++;
    if (errors <= 10) begin
      $display("%0t ns: %s", $realtime, what);
    end
  endtask

  // Bit-accurate prediction of one accepted item. Appends the bytes it
  // completes to owed_bytes_q and tags the final one with last.
  function automatic void pack_field(input logic                             op,
                                     input logic [lfbp_pkg::IN_VALUE_W-1:0]  v,
                                     input logic                             sgn,
                                     input logic [lfbp_pkg::BIT_COUNT_W-1:0] n);
    int unsigned  width;
    int unsigned  made;
    logic         sign_fill;
    logic         b;
    packed_byte_t e;
    if (op == lfbp_pkg::OP_DISCARD) begin
      held_bits  = '0;
      held_count = 0;
      return;
    end
    // Oversized widths clamp to the widest field.
    width     = (n > lfbp_pkg::MAX_FIELD_BITS) ? lfbp_pkg::MAX_FIELD_BITS : n;
    sign_fill = sgn & v[lfbp_pkg::VALUE_BITS-1];
    made      = 0;
    for (int i = 0; i < width; i++) begin
      // Above the value width the field repeats the sign (or zero).
      b = (i < lfbp_pkg::VALUE_BITS) ? v[i] : sign_fill;
      held_bits[held_count] = b;
      held_count++;
      if (held_count == lfbp_pkg::BYTE_W) begin
        e.data = held_bits;
        e.last = 1'b0;
        owed_bytes_q.push_back(e);
        made++;
        held_bits  = '0;
        held_count = 0;
      end
    end
    if (made > 0) begin
      owed_bytes_q[$].last = 1'b1;
    end
  endfunction

  // Offer one item, with optional random gaps, and wait for the transfer.
  // valid is left high afterward; the next call or the end of the run
  // decides whether it drops, so it never gets two updates in one step.
  task automatic send_item(input logic                             op,
                           input logic [lfbp_pkg::IN_VALUE_W-1:0]  v,
                           input logic                             sgn,
                           input logic [lfbp_pkg::BIT_COUNT_W-1:0] n);
    while (in_gaps_on && ($urandom_range(99) < 37)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= v;
    in_ch.is_signed <= sgn;
    in_ch.bit_count <= n;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    pack_field(op, v, sgn, n);
  endtask

  // Random width: mostly legal 1..64, some zero, some oversized.
  function automatic logic [lfbp_pkg::BIT_COUNT_W-1:0] pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) begin
      return lfbp_pkg::BIT_COUNT_W'($urandom_range(127, lfbp_pkg::MAX_FIELD_BITS + 1));
    end else if (r < 15) begin
      return '0;
    end
    return lfbp_pkg::BIT_COUNT_W'($urandom_range(lfbp_pkg::MAX_FIELD_BITS, 1));
  endfunction

  // One random item: mostly puts, with the occasional discard carrying junk.
  task automatic send_random_item(input bit wide_only);
    logic [lfbp_pkg::IN_VALUE_W-1:0]  v;
    logic [lfbp_pkg::BIT_COUNT_W-1:0] n;
    v = $urandom();
    // Force the top bit half the time so sign extension is exercised hard.
    if ($urandom_range(1)) begin
      v[lfbp_pkg::IN_VALUE_W-1] = 1'b1;
    end
    n = wide_only ? lfbp_pkg::BIT_COUNT_W'($urandom_range(lfbp_pkg::MAX_FIELD_BITS, 40))
                  : pick_width();
    if (!wide_only && ($urandom_range(99) < 8)) begin
      send_item(lfbp_pkg::OP_DISCARD, v, 1'($urandom_range(1)), n);
    end else begin
      send_item(lfbp_pkg::OP_PUT, v, 1'($urandom_range(1)), n);
    end
  endtask

  // Field extremes, both sign-fill cases, clamp, partial bytes, discards.
  task automatic test_directed();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    send_item(lfbp_pkg::OP_PUT,     32'hffff_ffff, 1'b1, 7'd0);    // zero width: nothing
    send_item(lfbp_pkg::OP_PUT,     32'h0000_0005, 1'b0, 7'd3);    // no byte completed
    send_item(lfbp_pkg::OP_PUT,     32'h0000_001f, 1'b0, 7'd5);    // completes first byte
    send_item(lfbp_pkg::OP_PUT,     32'h0000_00a5, 1'b0, 7'd8);
    send_item(lfbp_pkg::OP_PUT,     32'hffff_ffff, 1'b0, 7'd32);
    send_item(lfbp_pkg::OP_PUT,     32'h8000_0001, 1'b1, 7'd64);   // negative: ones above
    send_item(lfbp_pkg::OP_PUT,     32'h8000_0000, 1'b0, 7'd64);   // unsigned: zeros above
    send_item(lfbp_pkg::OP_PUT,     32'h7fff_ffff, 1'b1, 7'd64);   // positive signed
    send_item(lfbp_pkg::OP_PUT,     32'h0000_0055, 1'b0, 7'd7);    // seven held
    send_item(lfbp_pkg::OP_PUT,     32'h0000_0001, 1'b0, 7'd1);    // tops up the byte
    send_item(lfbp_pkg::OP_PUT,     32'h0000_000f, 1'b0, 7'd4);
    send_item(lfbp_pkg::OP_DISCARD, 32'hffff_ffff, 1'b1, 7'd127);  // drops the four held
    send_item(lfbp_pkg::OP_PUT,     32'h0000_003c, 1'b0, 7'd8);
    send_item(lfbp_pkg::OP_PUT,     32'hdead_beef, 1'b1, 7'd127);  // clamps to 64
    send_item(lfbp_pkg::OP_PUT,     32'h1234_5678, 1'b0, 7'd65);   // clamps to 64
    send_item(lfbp_pkg::OP_PUT,     32'h8000_0000, 1'b1, 7'd96);
    send_item(lfbp_pkg::OP_PUT,     32'h8000_0000, 1'b1, 7'd33);   // one bit left over
    send_item(lfbp_pkg::OP_PUT,     32'h0000_0000, 1'b0, 7'd40);
    send_item(lfbp_pkg::OP_PUT,     32'h0000_0007, 1'b0, 7'd3);
    send_item(lfbp_pkg::OP_DISCARD, 32'h0000_0000, 1'b0, 7'd0);
    send_item(lfbp_pkg::OP_DISCARD, 32'h0000_0000, 1'b0, 7'd0);    // nothing to drop
    send_item(lfbp_pkg::OP_PUT,     32'hffff_ffff, 1'b1, 7'd63);
    send_item(lfbp_pkg::OP_PUT,     32'h0000_0000, 1'b0, 7'd1);
    send_item(lfbp_pkg::OP_PUT,     32'h0000_0002, 1'b0, 7'd2);
  endtask

  task automatic test_random_gaps(input int count);
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    repeat (count) send_random_item(1'b0);
  endtask

  // Back-to-back transfers on both sides.
  task automatic test_full_rate(input int count);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    repeat (count) send_random_item(1'b0);
  endtask

  // Receiver holds off while wide items keep coming: the packer must fill
  // and drop in_ch.ready without losing or reordering bytes.
  task automatic test_back_pressure();
    in_gaps_on   = 1'b0;
    out_gaps_on  = 1'b1;
    hold_off_req = 150;
    repeat (40) send_random_item(1'b1);
  endtask

  // Receiver: random stalls, plus a counted hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(out_gaps_on && ($urandom_range(99) < 37));
      end
    end
  end

  // Byte checker: every output transfer against the oldest owed byte.
  always @(posedge clk) begin
    packed_byte_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_bytes_q.size() == 0) begin
        log_failure($sformatf("unexpected byte %02h last %0b", out_ch.out_byte, out_ch.last));
      end else begin
        e = owed_bytes_q.pop_front();
        if (out_ch.out_byte !== e.data) begin
          log_failure($sformatf("byte mismatch: expected %02h, got %02h",
                                e.data, out_ch.out_byte));
        end
        if (out_ch.last !== e.last) begin
          log_failure($sformatf("last mismatch on byte %02h: expected %0b, got %0b",
                                e.data, e.last, out_ch.last));
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int guard;
    errors          = 0;
    held_bits       = '0;
    held_count      = 0;
    in_gaps_on      = 1'b0;
    out_gaps_on     = 1'b0;
    hold_off_req    = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = lfbp_pkg::OP_PUT;
    in_ch.value     = '0;
    in_ch.is_signed = 1'b0;
    in_ch.bit_count = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_gaps(250);
    test_full_rate(80);
    test_back_pressure();
    test_random_gaps(60);

    in_ch.valid <= 1'b0;
    // Drain: wait for every owed byte, bounded, then keep idling to catch anything extra.
    guard = 0;
    while ((owed_bytes_q.size() != 0) && (guard < 20000)) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (owed_bytes_q.size() != 0) begin
      log_failure($sformatf("%0d bytes never arrived", owed_bytes_q.size()));
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
src/lfbp_pkg.sv
src/lfbp_if.sv
src/lfbp_ctrl.sv
src/lfbp_dp.sv
src/lsb_first_bit_packer.sv
verif/tb_lsb_first_bit_packer.sv
